@@ hw/rtl/fsnm_pkg.sv @@
// Shared types and constants for the FAT 8.3 short-name matcher.
// No dependencies; used by fsnm_name_store and fat_short_name_matcher_core.
`default_nettype none

package fsnm_pkg;

  localparam int unsigned NameLen = 11;
  localparam int unsigned BaseLen = 8;
  localparam int unsigned PosW    = 4;

  localparam logic [7:0] PadChar     = 8'h20;
  localparam logic [7:0] DotChar     = 8'h2E;
  localparam logic [7:0] NulChar     = 8'h00;
  localparam logic [7:0] DeletedMark = 8'hE5;
  localparam logic [7:0] KanjiE5     = 8'h05;
  localparam logic [7:0] LowerA      = 8'h61;
  localparam logic [7:0] LowerZ      = 8'h7A;
  localparam logic [7:0] CaseDelta   = 8'h20;
  localparam logic [7:0] AttrDir     = 8'h10;
  localparam logic [7:0] AttrVolDir  = 8'h18;

  localparam logic FuncName  = 1'b0;
  localparam logic FuncEntry = 1'b1;
  localparam logic KindName  = 1'b0;
  localparam logic KindEntry = 1'b1;

  // one search-name character handed to the name store
  typedef struct packed {
    logic       valid;
    logic [7:0] ch;
    logic       last;
  } name_cmd_t;

  // name store status back to the top level
  typedef struct packed {
    logic bad;      // current invalid flag
    logic bad_nxt;  // flag after the character in flight
    logic done;     // character in flight closes the name
  } name_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/fat_short_name_matcher_core.sv @@
// FAT 8.3 short-name matcher: builds the search name, compares directory entries.
// Depends on fsnm_pkg and fsnm_name_store.
//
//   channel | handshake          | payload
//   --------+--------------------+-------------------------------------------
//   in      | in_valid/in_ready  | in_func, in_data_byte, in_last_char
//   out     | out_valid/out_ready| out_result_kind, out_name_invalid,
//           |                    | out_entry_match
//   cfg     | cfg_we             | cfg_wdata (want_directory)
//
// An item is taken into the input register, processed there and its result
// (if any) lands in the output register; one item per cycle is sustained while
// the output is not stalled. The input register advances whenever the
// output register is empty or being drained, so a waiting result holds every
// item in the input register, whether or not it produces a result. Reset
// gives a blank name, no open name or entry, and a plain-file search.
`default_nettype none

module fat_short_name_matcher_core (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       in_func,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_last_char,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_result_kind,
  output logic            out_name_invalid,
  output logic            out_entry_match,
  input  wire logic       cfg_we,
  input  wire logic       cfg_wdata
);

  logic                      want_dir_r;
  logic                      s_valid_r;
  logic                      s_func_r;
  logic [7:0]                s_byte_r;
  logic                      s_last_r;
  logic                      advance;

  logic [fsnm_pkg::PosW-1:0] ep_r, ep_nxt;
  logic                      differs_r, differs_nxt;
  logic                      ov_r, ov_nxt;
  logic                      okind_r, okind_nxt;
  logic                      oinv_r, oinv_nxt;
  logic                      omatch_r, omatch_nxt;
  logic                      attr_ok;

  fsnm_pkg::name_cmd_t       cmd;
  fsnm_pkg::name_stat_t      stat;
  logic [7:0]                rd_byte;

  assign advance  = s_valid_r && (!ov_r || out_ready);
  assign in_ready = !s_valid_r || advance;

  assign cmd.valid = advance && (s_func_r == fsnm_pkg::FuncName);
  assign cmd.ch    = s_byte_r;
  assign cmd.last  = s_last_r;

  fsnm_name_store u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .rd_idx (ep_r),
    .rd_byte(rd_byte),
    .stat   (stat)
  );

  assign attr_ok = want_dir_r ? ((s_byte_r & fsnm_pkg::AttrDir) != 8'h00)
                              : ((s_byte_r & fsnm_pkg::AttrVolDir) == 8'h00);

  always_comb begin
    ep_nxt      = ep_r;
    differs_nxt = differs_r;
    ov_nxt      = ov_r && !out_ready;
    okind_nxt   = okind_r;
    oinv_nxt    = oinv_r;
    omatch_nxt  = omatch_r;
    if (advance) begin
      if (s_func_r == fsnm_pkg::FuncName) begin
        if (stat.done) begin
          ov_nxt     = 1'b1;
          okind_nxt  = fsnm_pkg::KindName;
          oinv_nxt   = stat.bad_nxt;
          omatch_nxt = 1'b0;
        end
      end else if (ep_r < fsnm_pkg::PosW'(fsnm_pkg::NameLen)) begin
        if (rd_byte != s_byte_r) begin
          differs_nxt = 1'b1;
        end
        ep_nxt = ep_r + 1'b1;
      end else begin
        // attribute byte closes the entry
        ov_nxt      = 1'b1;
        okind_nxt   = fsnm_pkg::KindEntry;
        oinv_nxt    = stat.bad;
        omatch_nxt  = attr_ok && !differs_r && !stat.bad;
        ep_nxt      = '0;
        differs_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      want_dir_r <= 1'b0;
      s_valid_r  <= 1'b0;
      ep_r       <= '0;
      differs_r  <= 1'b0;
      ov_r       <= 1'b0;
    end else begin
      if (cfg_we) begin
        want_dir_r <= cfg_wdata;
      end
      if (in_ready) begin
        s_valid_r <= in_valid;
      end
      ep_r      <= ep_nxt;
      differs_r <= differs_nxt;
      ov_r      <= ov_nxt;
    end
  end

  // payload registers: no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s_func_r <= in_func;
      s_byte_r <= in_data_byte;
      s_last_r <= in_last_char;
    end
    okind_r  <= okind_nxt;
    oinv_r   <= oinv_nxt;
    omatch_r <= omatch_nxt;
  end

  assign out_valid        = ov_r;
  assign out_result_kind  = okind_r;
  assign out_name_invalid = oinv_r;
  assign out_entry_match  = omatch_r;

endmodule

`default_nettype wire

@@ hw/rtl/fsnm_name_store.sv @@
// Builds and holds the 11-byte short name from search-name characters.
// Depends on fsnm_pkg.
`default_nettype none

module fsnm_name_store (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire fsnm_pkg::name_cmd_t         cmd,
  input  wire logic [fsnm_pkg::PosW-1:0]   rd_idx,
  output logic [7:0]                       rd_byte,
  output fsnm_pkg::name_stat_t             stat
);

  logic [7:0]                name_r [fsnm_pkg::NameLen];
  logic [7:0]                name_nxt [fsnm_pkg::NameLen];
  logic [fsnm_pkg::PosW-1:0] wp_r, wp_nxt;
  logic                      ext_r, ext_nxt;
  logic                      bad_r, bad_nxt;
  logic                      open_r, open_nxt;
  logic [7:0]                val;
  logic                      done;

  always_comb begin
    name_nxt = name_r;
    wp_nxt   = wp_r;
    ext_nxt  = ext_r;
    bad_nxt  = bad_r;
    open_nxt = open_r;
    done     = 1'b0;
    val      = cmd.ch;
    if (cmd.valid) begin
      // first character of a new name: start from a blank name
      if (!open_r) begin
        for (int k = 0; k < fsnm_pkg::NameLen; k++) begin
          name_nxt[k] = fsnm_pkg::PadChar;
        end
        wp_nxt  = '0;
        ext_nxt = 1'b0;
        bad_nxt = 1'b0;
      end
      if (cmd.ch != fsnm_pkg::NulChar && !bad_nxt) begin
        if (cmd.ch == fsnm_pkg::DotChar && !ext_nxt) begin
          ext_nxt = 1'b1;
          wp_nxt  = fsnm_pkg::PosW'(fsnm_pkg::BaseLen);
        end else if ((!ext_nxt && wp_nxt >= fsnm_pkg::PosW'(fsnm_pkg::BaseLen)) ||
                     wp_nxt >= fsnm_pkg::PosW'(fsnm_pkg::NameLen)) begin
          bad_nxt = 1'b1;
        end else begin
          if (cmd.ch == fsnm_pkg::DeletedMark && !ext_nxt && wp_nxt == '0) begin
            val = fsnm_pkg::KanjiE5;
          end else if (cmd.ch >= fsnm_pkg::LowerA && cmd.ch <= fsnm_pkg::LowerZ) begin
            val = cmd.ch - fsnm_pkg::CaseDelta;
          end
          name_nxt[wp_nxt] = val;
          wp_nxt = wp_nxt + 1'b1;
        end
      end
      done     = (cmd.ch == fsnm_pkg::NulChar) || cmd.last;
      open_nxt = !done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < fsnm_pkg::NameLen; k++) begin
        name_r[k] <= fsnm_pkg::PadChar;
      end
      wp_r   <= '0;
      ext_r  <= 1'b0;
      bad_r  <= 1'b0;
      open_r <= 1'b0;
    end else begin
      name_r <= name_nxt;
      wp_r   <= wp_nxt;
      ext_r  <= ext_nxt;
      bad_r  <= bad_nxt;
      open_r <= open_nxt;
    end
  end

  assign rd_byte = (rd_idx < fsnm_pkg::PosW'(fsnm_pkg::NameLen)) ? name_r[rd_idx]
                                                                 : fsnm_pkg::PadChar;

  assign stat.bad     = bad_r;
  assign stat.bad_nxt = bad_nxt;
  assign stat.done    = done;

endmodule

`default_nettype wire

@@ sim/fsnm_match_checker.sv @@
// Watches the item channels of the FAT 8.3 short-name matcher, predicts each
// result and compares it with what the block returns. Depends on fsnm_pkg.
`timescale 1ns / 1ps

module fsnm_match_checker (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic       in_ready,
  input  wire logic       in_func,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_last_char,
  input  wire logic       out_valid,
  input  wire logic       out_ready,
  input  wire logic       out_result_kind,
  input  wire logic       out_name_invalid,
  input  wire logic       out_entry_match,
  input  wire logic       cfg_we,
  input  wire logic       cfg_wdata,
  output int              error_count,
  output int              verdicts_due
);

  typedef struct packed {
    logic kind;
    logic bad;
    logic hit;
  } verdict_t;

  verdict_t verdict_q[$];
  int       fails = 0;

  // predicted block state
  logic [7:0]                form [fsnm_pkg::NameLen];
  logic [fsnm_pkg::PosW-1:0] fill_pos;
  logic [fsnm_pkg::PosW-1:0] scan_pos;
  logic                      in_ext;
  logic                      too_long;
  logic                      open_name;
  logic                      scan_miss;
  logic                      want_dir;

  task automatic clear_form();
    foreach (form[k]) form[k] = fsnm_pkg::PadChar;
    fill_pos = '0;
    in_ext   = 1'b0;
    too_long = 1'b0;
  endtask

  // Advance the predicted state by one item; queue the verdict it causes.
  task automatic absorb_item(input logic f, input logic [7:0] b, input logic l);
    logic [7:0] v;
    logic       attr_ok;
    if (f == fsnm_pkg::FuncName) begin
      if (!open_name) begin
        clear_form();
        open_name = 1'b1;
      end
      if (b != fsnm_pkg::NulChar && !too_long) begin
        if (b == fsnm_pkg::DotChar && !in_ext) begin
          in_ext   = 1'b1;
          fill_pos = fsnm_pkg::PosW'(fsnm_pkg::BaseLen);
        end else if ((!in_ext && fill_pos >= fsnm_pkg::BaseLen) ||
                     fill_pos >= fsnm_pkg::NameLen) begin
          too_long = 1'b1;
        end else begin
          if (b == fsnm_pkg::DeletedMark && !in_ext && fill_pos == 0)
            v = fsnm_pkg::KanjiE5;
          else if (b >= fsnm_pkg::LowerA && b <= fsnm_pkg::LowerZ)
            v = b - fsnm_pkg::CaseDelta;
          else
            v = b;
          form[fill_pos] = v;
          fill_pos = fill_pos + 1'b1;
        end
      end
      if (b == fsnm_pkg::NulChar || l) begin
        open_name = 1'b0;
        verdict_q.push_back(verdict_t'{fsnm_pkg::KindName, too_long, 1'b0});
      end
    end else if (scan_pos < fsnm_pkg::NameLen) begin
      if (form[scan_pos] != b) scan_miss = 1'b1;
      scan_pos = scan_pos + 1'b1;
    end else begin
      // attribute byte closes the entry
      attr_ok = want_dir ? ((b & fsnm_pkg::AttrDir) != 0)
                         : ((b & fsnm_pkg::AttrVolDir) == 0);
      verdict_q.push_back(verdict_t'{fsnm_pkg::KindEntry, too_long,
                                     attr_ok && !scan_miss && !too_long});
      scan_pos  = '0;
      scan_miss = 1'b0;
    end
  endtask

  task automatic check_bit(input string what, input logic want, input logic got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %b, actual %b", $time, what, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin : watch
    verdict_t vd;
    if (!rst_n) begin
      clear_form();
      open_name = 1'b0;
      scan_pos  = '0;
      scan_miss = 1'b0;
      want_dir  = 1'b0;
      verdict_q.delete();
    end else begin
      if (cfg_we) want_dir = cfg_wdata;
      if (in_valid && in_ready) absorb_item(in_func, in_data_byte, in_last_char);
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, actual kind %b invalid %b match %b",
                   $time, out_result_kind, out_name_invalid, out_entry_match);
          fails++;
        end else begin
          vd = verdict_q.pop_front();
          check_bit("result_kind", vd.kind, out_result_kind);
          check_bit("name_invalid", vd.bad, out_name_invalid);
          check_bit("entry_match", vd.hit, out_entry_match);
        end
      end
    end
    error_count  <= fails;
    verdicts_due <= verdict_q.size();
  end

endmodule

@@ sim/tb_fat_short_name_matcher_core.sv @@
// Stimulus and verdict for fat_short_name_matcher_core: search names, directory
// entries and mode switches. Depends on fsnm_pkg and fsnm_match_checker.
`timescale 1ns / 1ps

module tb_fat_short_name_matcher_core;

  localparam int CycleLimit = 100000;
  localparam int PhaseItems = 430;

  logic       clk;
  logic       rst_n        = 1'b0;
  logic       in_valid     = 1'b0;
  logic       in_ready;
  logic       in_func      = fsnm_pkg::FuncName;
  logic [7:0] in_data_byte = 8'h00;
  logic       in_last_char = 1'b0;
  logic       out_valid;
  logic       out_ready    = 1'b0;
  logic       out_result_kind;
  logic       out_name_invalid;
  logic       out_entry_match;
  logic       cfg_we       = 1'b0;
  logic       cfg_wdata    = 1'b0;

  int error_count;
  int verdicts_due;
  int cycles       = 0;
  int sent         = 0;
  int entry_phase  = 0;
  int hold_left    = 0;
  bit name_pending = 1'b0;
  bit calm         = 1'b0;
  bit hold_req     = 1'b0;

  // upper-case padded form of the last generated name, used to build entries
  logic [7:0] target [fsnm_pkg::NameLen];

  fat_short_name_matcher_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_data_byte     (in_data_byte),
    .in_last_char     (in_last_char),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_kind  (out_result_kind),
    .out_name_invalid (out_name_invalid),
    .out_entry_match  (out_entry_match),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata)
  );

  fsnm_match_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_data_byte     (in_data_byte),
    .in_last_char     (in_last_char),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_kind  (out_result_kind),
    .out_name_invalid (out_name_invalid),
    .out_entry_match  (out_entry_match),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .error_count      (error_count),
    .verdicts_due     (verdicts_due)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 160;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 31);
      end
    end
  end

  // Offer one item and hold it until accepted.
  task automatic send_item(input logic f, input logic [7:0] b, input logic l);
    while (!calm && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_func      <= f;
    in_data_byte <= b;
    in_last_char <= l;
    do @(posedge clk); while (!in_ready);
    sent++;
    if (f == fsnm_pkg::FuncEntry)
      entry_phase = (entry_phase == fsnm_pkg::NameLen) ? 0 : entry_phase + 1;
    else
      name_pending = (b != fsnm_pkg::NulChar) && !l;
  endtask

  task automatic settle_and_configure(input logic dir_mode);
    in_valid <= 1'b0;
    @(posedge clk);
    while (verdicts_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= dir_mode;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [7:0] pick_char(input bit dot_ok);
    logic [7:0] c;
    case ($urandom_range(9))
      0, 1, 2, 3: c = fsnm_pkg::LowerA + 8'($urandom_range(25));
      4, 5:       c = 8'h41 + 8'($urandom_range(25));
      6:          c = 8'h30 + 8'($urandom_range(9));
      7:          c = fsnm_pkg::DeletedMark;
      8:          c = dot_ok ? fsnm_pkg::DotChar : 8'h5F;
      default:    c = 8'($urandom_range(1, 255));
    endcase
    if (!dot_ok && c == fsnm_pkg::DotChar) c = 8'h7E;
    return c;
  endfunction

  function automatic logic [7:0] raise_case(input logic [7:0] c);
    return (c >= fsnm_pkg::LowerA && c <= fsnm_pkg::LowerZ) ? c - fsnm_pkg::CaseDelta : c;
  endfunction

  // Well-formed search name with random content; go_long makes it too long.
  task automatic send_name(input bit go_long);
    logic [7:0] chars[$];
    logic [7:0] c;
    int         base_n;
    int         ext_n;
    int         ending;
    int         cut;
    bit         dotted;
    if (name_pending) send_item(fsnm_pkg::FuncName, fsnm_pkg::NulChar, 1'($urandom));
    foreach (target[k]) target[k] = fsnm_pkg::PadChar;
    base_n = $urandom_range(8);
    ext_n  = $urandom_range(3);
    dotted = $urandom_range(3) != 0;
    if (go_long) begin
      if ($urandom_range(1)) begin
        base_n = $urandom_range(9, 12);
      end else begin
        dotted = 1'b1;
        ext_n  = $urandom_range(4, 5);
      end
    end
    if (!dotted) ext_n = 0;
    for (int i = 0; i < base_n; i++) begin
      c = pick_char(1'b0);
      chars.push_back(c);
      if (i < fsnm_pkg::BaseLen)
        target[i] = (i == 0 && c == fsnm_pkg::DeletedMark) ? fsnm_pkg::KanjiE5
                                                           : raise_case(c);
    end
    if (dotted) begin
      chars.push_back(fsnm_pkg::DotChar);
      for (int j = 0; j < ext_n; j++) begin
        c = pick_char(1'b1);
        chars.push_back(c);
        if (j < fsnm_pkg::NameLen - fsnm_pkg::BaseLen)
          target[fsnm_pkg::BaseLen + j] = raise_case(c);
      end
    end
    // end by last flag, by NUL, or by NUL with last flag
    ending = (chars.size() == 0) ? $urandom_range(1, 2) : $urandom_range(2);
    cut    = ($urandom_range(7) == 0) ? $urandom_range(chars.size()) : -1;
    foreach (chars[i]) begin
      if (i == cut) send_item(fsnm_pkg::FuncEntry, 8'($urandom), 1'($urandom));
      send_item(fsnm_pkg::FuncName, chars[i], ending == 0 && i == chars.size() - 1);
    end
    if (ending != 0) send_item(fsnm_pkg::FuncName, fsnm_pkg::NulChar, ending == 2);
  endtask

  // Directory entry built from the last name, exact or with one bit flipped.
  task automatic send_entry();
    logic [7:0] b;
    int         flip;
    bit         exact;
    while (entry_phase != 0) send_item(fsnm_pkg::FuncEntry, 8'($urandom), 1'($urandom));
    exact = $urandom_range(99) < 60;
    flip  = $urandom_range(fsnm_pkg::NameLen - 1);
    for (int k = 0; k < fsnm_pkg::NameLen; k++) begin
      b = target[k];
      if (!exact && k == flip) b = b ^ 8'(1 << $urandom_range(7));
      send_item(fsnm_pkg::FuncEntry, b, 1'($urandom));
    end
    case ($urandom_range(4))
      0:       b = 8'h00;
      1:       b = fsnm_pkg::AttrDir;
      2:       b = fsnm_pkg::AttrVolDir & ~fsnm_pkg::AttrDir;
      3:       b = 8'hFF;
      default: b = 8'($urandom);
    endcase
    send_item(fsnm_pkg::FuncEntry, b, 1'($urandom));
  endtask

  initial begin : stimulus
    int goal;
    int pick;
    foreach (target[k]) target[k] = fsnm_pkg::PadChar;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    settle_and_configure(1'b0);

    // deleted mark in front, lower case, dot, last flag
    send_item(fsnm_pkg::FuncName, fsnm_pkg::DeletedMark, 1'b0);
    send_item(fsnm_pkg::FuncName, fsnm_pkg::LowerA, 1'b0);
    send_item(fsnm_pkg::FuncName, fsnm_pkg::DotChar, 1'b0);
    send_item(fsnm_pkg::FuncName, 8'h62, 1'b1);
    // matching plain-file entry; last flag on entry bytes must be ignored
    for (int k = 0; k < fsnm_pkg::NameLen; k++)
      send_item(fsnm_pkg::FuncEntry, (k == 0) ? fsnm_pkg::KanjiE5 : (k == 1) ? 8'h41 :
                (k == fsnm_pkg::BaseLen) ? 8'h42 : fsnm_pkg::PadChar, 1'(k));
    send_item(fsnm_pkg::FuncEntry, 8'h00, 1'b1);
    // NUL together with last flag
    send_item(fsnm_pkg::FuncName, fsnm_pkg::LowerZ, 1'b0);
    send_item(fsnm_pkg::FuncName, fsnm_pkg::NulChar, 1'b1);
    // nine-character base
    for (int k = 0; k < 9; k++)
      send_item(fsnm_pkg::FuncName, 8'hFF - 8'(k), k == 8);

    for (int ph = 0; ph < 4; ph++) begin
      settle_and_configure(!ph[0]);
      calm = (ph == 2);
      if (ph == 1) hold_req = 1'b1;
      goal = sent + PhaseItems;
      while (sent < goal) begin
        pick = $urandom_range(99);
        if (pick < 40)
          send_name($urandom_range(99) < 15);
        else if (pick < 90)
          send_entry();
        else
          repeat ($urandom_range(1, 6))
            send_item(1'($urandom), ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom),
                      1'($urandom));
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (verdicts_due != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
